### sv/assert_macros.svh
// Assertion macros used by the checker file of the Miller-Rabin block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define MRW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("miller-rabin checker: property failed");

// Clocked property that also holds across reset.
`define MRW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("miller-rabin checker: property failed");

`endif

### sv/mrw_pkg.sv
// Shared types and constants of the Miller-Rabin witness block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mrw_pkg;

   localparam int FIELD_W   = 32;   // width of modulus and witness on the bus
   localparam int VERDICT_W = 2;

   localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_COMPOSITE = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_INVALID   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPLIT,
      ST_POW_TEST,
      ST_POW_ACC,
      ST_POW_BASE,
      ST_START_TEST,
      ST_SQ_TEST,
      ST_SQ_WAIT,
      ST_SQ_CHECK,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_ACC_BASE,
      MUL_BASE_BASE,
      MUL_ACC_ACC
   } mul_sel_type;

   typedef struct packed {
      logic                 load;         // capture a new item
      logic                 d_shift;      // drop the low bit of d
      logic                 s_inc;        // count a factor of two
      logic                 s_dec;        // use up one squaring
      logic                 mul_start;
      mul_sel_type          mul_sel;
      logic                 write_acc;
      logic                 write_base;
      logic                 set_verdict;
      logic [VERDICT_W-1:0] verdict;
      logic                 emit;         // move verdict to output register
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;
      logic d_lsb;
      logic d_zero;
      logic acc_one;
      logic acc_pm1;
      logic s_gt1;
      logic mul_done;
      logic out_free;
   } dp_status_type;

endpackage

### sv/miller_rabin_witness_test.sv
// Top level of the Miller-Rabin witness test: one round per item.
// Depends on mrw_pkg, mrw_ctrl, mrw_datapath (and mrw_modmul below it).
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata[63:0]: modulus, witness
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata[7:0]:  verdict
//
// Order: one item at a time. Each modular multiplication runs on a single
// shift-add multiplier; an invalid item skips the arithmetic.
// Reset: synchronous, clears the controller and the output valid flag.
// Stalls: a finished verdict waits in the output register; a new item is
// accepted while it waits, and the next verdict holds back until it is taken.
module miller_rabin_witness_test #(
   parameter int MOD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [31:0] modulus, [63:32] witness
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata     // [1:0] verdict, [7:2] zero
);

   localparam int FW = mrw_pkg::FIELD_W;

   mrw_pkg::dp_cmd_type    cmd;
   mrw_pkg::dp_status_type status;
   logic [mrw_pkg::VERDICT_W-1:0] verdict;

   // sequencing: split p-1, square-and-multiply, then the squaring chain
   mrw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // operands, the multiplier and the output register
   mrw_datapath #(.W(MOD_WIDTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_modulus  (req_tdata[FW-1:0]),
      .in_witness  (req_tdata[2*FW-1:FW]),
      .cmd         (cmd),
      .status      (status),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_verdict (verdict)
   );

   // pad the verdict up to a whole byte
   assign rsp_tdata = {6'b0, verdict};

endmodule

### sv/mrw_modmul.sv
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on nothing; instantiated by mrw_datapath.
module mrw_modmul #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] modulus,   // held stable while busy
   output logic [W-1:0] result,
   output logic         done
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W+1:0]  sum;
   logic [W+1:0]  m1;
   logic [W+1:0]  m2;

   // r < m, so 2r + x < 3m; reduce by 0, m or 2m
   always_comb begin
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      sum = {1'b0, r_ff, 1'b0} + (y_ff[W-1] ? {2'b00, x_ff} : '0);
      if (sum >= m2) begin
         sum = sum - m2;
      end else if (sum >= m1) begin
         sum = sum - m1;
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = opa;
         y_in    = opb;
         r_in    = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = sum[W-1:0];
         y_in   = {y_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result = r_ff;
   assign done   = done_ff;

endmodule

### sv/mrw_datapath.sv
// Datapath of the Miller-Rabin block: operand registers, d/s split, modular
// multiplier and output register. Depends on mrw_pkg and mrw_modmul.
module mrw_datapath #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mrw_pkg::FIELD_W-1:0]   in_modulus,
   input  logic [mrw_pkg::FIELD_W-1:0]   in_witness,
   input  mrw_pkg::dp_cmd_type           cmd,
   output mrw_pkg::dp_status_type        status,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [mrw_pkg::VERDICT_W-1:0] out_verdict
);

   localparam int SW = $clog2(W);
   localparam int FW = mrw_pkg::FIELD_W;

   logic [W-1:0]  p_ff, p_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  base_ff, base_in;
   logic [SW-1:0] s_ff, s_in;
   logic          invalid_ff, invalid_in;
   logic [mrw_pkg::VERDICT_W-1:0] verdict_ff, verdict_in;
   logic [mrw_pkg::VERDICT_W-1:0] out_verdict_ff, out_verdict_in;
   logic          out_valid_ff, out_valid_in;
   logic [W-1:0]  mul_a;
   logic [W-1:0]  mul_b;
   logic [W-1:0]  mul_result;
   logic          mul_done;
   logic          bad_item;

   // too wide, below five, even, or witness outside 2..p-2
   always_comb begin
      bad_item = ({1'b0, in_modulus} >= ((FW + 1)'(1) << W))
              || (in_modulus < FW'(5))
              || !in_modulus[0]
              || (in_witness < FW'(2))
              || (in_witness > (in_modulus - FW'(2)));
   end

   always_comb begin
      case (cmd.mul_sel)
         mrw_pkg::MUL_ACC_BASE: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         mrw_pkg::MUL_BASE_BASE: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         mrw_pkg::MUL_ACC_ACC: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
      endcase
   end

   mrw_modmul #(.W(W)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .opa     (mul_a),
      .opb     (mul_b),
      .modulus (p_ff),
      .result  (mul_result),
      .done    (mul_done)
   );

   always_comb begin
      p_in           = p_ff;
      d_in           = d_ff;
      acc_in         = acc_ff;
      base_in        = base_ff;
      s_in           = s_ff;
      invalid_in     = invalid_ff;
      verdict_in     = verdict_ff;
      out_verdict_in = out_verdict_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      if (cmd.load) begin
         p_in       = in_modulus[W-1:0];
         d_in       = in_modulus[W-1:0] - W'(1);
         acc_in     = W'(1);
         base_in    = in_witness[W-1:0];   // witness < p, already reduced
         s_in       = '0;
         invalid_in = bad_item;
      end
      if (cmd.d_shift) begin
         d_in = {1'b0, d_ff[W-1:1]};
      end
      if (cmd.s_inc) begin
         s_in = s_ff + 1'b1;
      end
      if (cmd.s_dec) begin
         s_in = s_ff - 1'b1;
      end
      if (cmd.write_acc) begin
         acc_in = mul_result;
      end
      if (cmd.write_base) begin
         base_in = mul_result;
      end
      if (cmd.set_verdict) begin
         verdict_in = cmd.verdict;
      end
      if (cmd.emit) begin
         out_verdict_in = verdict_ff;
         out_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      p_ff           <= p_in;
      d_ff           <= d_in;
      acc_ff         <= acc_in;
      base_ff        <= base_in;
      s_ff           <= s_in;
      invalid_ff     <= invalid_in;
      verdict_ff     <= verdict_in;
      out_verdict_ff <= out_verdict_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      status.invalid  = invalid_ff;
      status.d_lsb    = d_ff[0];
      status.d_zero   = (d_ff == '0);
      status.acc_one  = (acc_ff == W'(1));
      status.acc_pm1  = (acc_ff == (p_ff - W'(1)));
      status.s_gt1    = (s_ff > SW'(1));
      status.mul_done = mul_done;
      status.out_free = !out_valid_ff || out_ready;
   end

   assign out_valid   = out_valid_ff;
   assign out_verdict = out_verdict_ff;

endmodule

### sv/mrw_ctrl.sv
// Controller state machine of the Miller-Rabin block.
// Depends on mrw_pkg; drives mrw_datapath through command and status structs.
module mrw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mrw_pkg::dp_status_type status,
   output mrw_pkg::dp_cmd_type    cmd
);

   mrw_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrw_pkg::ST_IDLE: begin
            if (in_valid) begin
               state_in = mrw_pkg::ST_CHECK;
            end
         end
         mrw_pkg::ST_CHECK: begin
            state_in = status.invalid ? mrw_pkg::ST_FINISH : mrw_pkg::ST_SPLIT;
         end
         mrw_pkg::ST_SPLIT: begin
            if (status.d_lsb) begin
               state_in = mrw_pkg::ST_POW_TEST;
            end
         end
         mrw_pkg::ST_POW_TEST: begin
            if (status.d_zero) begin
               state_in = mrw_pkg::ST_START_TEST;
            end else if (status.d_lsb) begin
               state_in = mrw_pkg::ST_POW_ACC;
            end else begin
               state_in = mrw_pkg::ST_POW_BASE;
            end
         end
         mrw_pkg::ST_POW_ACC: begin
            if (status.mul_done) begin
               state_in = mrw_pkg::ST_POW_BASE;
            end
         end
         mrw_pkg::ST_POW_BASE: begin
            if (status.mul_done) begin
               state_in = mrw_pkg::ST_POW_TEST;
            end
         end
         mrw_pkg::ST_START_TEST: begin
            if (status.acc_one || status.acc_pm1) begin
               state_in = mrw_pkg::ST_FINISH;
            end else begin
               state_in = mrw_pkg::ST_SQ_TEST;
            end
         end
         mrw_pkg::ST_SQ_TEST: begin
            state_in = status.s_gt1 ? mrw_pkg::ST_SQ_WAIT : mrw_pkg::ST_FINISH;
         end
         mrw_pkg::ST_SQ_WAIT: begin
            if (status.mul_done) begin
               state_in = mrw_pkg::ST_SQ_CHECK;
            end
         end
         mrw_pkg::ST_SQ_CHECK: begin
            if (status.acc_one || status.acc_pm1) begin
               state_in = mrw_pkg::ST_FINISH;
            end else begin
               state_in = mrw_pkg::ST_SQ_TEST;
            end
         end
         mrw_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = mrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = mrw_pkg::MUL_ACC_ACC;
      cmd.verdict  = mrw_pkg::VERDICT_COMPOSITE;
      in_ready     = 1'b0;
      case (state_ff)
         mrw_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         mrw_pkg::ST_CHECK: begin
            cmd.set_verdict = status.invalid;
            cmd.verdict     = mrw_pkg::VERDICT_INVALID;
         end
         mrw_pkg::ST_SPLIT: begin
            cmd.d_shift = !status.d_lsb;
            cmd.s_inc   = !status.d_lsb;
         end
         mrw_pkg::ST_POW_TEST: begin
            cmd.mul_start = !status.d_zero;
            cmd.mul_sel   = status.d_lsb ? mrw_pkg::MUL_ACC_BASE : mrw_pkg::MUL_BASE_BASE;
         end
         mrw_pkg::ST_POW_ACC: begin
            cmd.write_acc = status.mul_done;
            cmd.mul_start = status.mul_done;   // base square reads only base
            cmd.mul_sel   = status.mul_done ? mrw_pkg::MUL_BASE_BASE
                                            : mrw_pkg::MUL_ACC_BASE;
         end
         mrw_pkg::ST_POW_BASE: begin
            cmd.write_base = status.mul_done;
            cmd.d_shift    = status.mul_done;
            cmd.mul_sel    = mrw_pkg::MUL_BASE_BASE;
         end
         mrw_pkg::ST_START_TEST: begin
            cmd.set_verdict = status.acc_one || status.acc_pm1;
            cmd.verdict     = mrw_pkg::VERDICT_PRIME;
         end
         mrw_pkg::ST_SQ_TEST: begin
            cmd.mul_start   = status.s_gt1;
            cmd.s_dec       = status.s_gt1;
            cmd.set_verdict = !status.s_gt1;
            cmd.verdict     = mrw_pkg::VERDICT_COMPOSITE;
         end
         mrw_pkg::ST_SQ_WAIT: begin
            cmd.write_acc = status.mul_done;
         end
         mrw_pkg::ST_SQ_CHECK: begin
            cmd.set_verdict = status.acc_one || status.acc_pm1;
            cmd.verdict     = status.acc_one ? mrw_pkg::VERDICT_COMPOSITE
                                             : mrw_pkg::VERDICT_PRIME;
         end
         mrw_pkg::ST_FINISH: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/mrw_checker.sv
// Port-level checker for the Miller-Rabin block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mrw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled verdict holds
   `MRW_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // verdict code three never appears, pad bits stay zero
   `MRW_ASSERT(a_rsp_code, clock, reset, rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[7:2] == 6'd0)

   // one item in work at a time
   `MRW_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // reset empties the output register
   `MRW_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)

endmodule

bind miller_rabin_witness_test mrw_checker u_mrw_checker (.*);
